// ----- design/cpb_pkg.sv -----
// ----------------------------------------------------------------------------
// cpb_pkg
// Shared types, codes and widths for the clipped pixel blend unit.
// ----------------------------------------------------------------------------
package cpb_pkg;

    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int COLOR_W   = CHAN_W * NUM_CHAN;
    localparam int COORD_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    // blend modes
    localparam logic [MODE_W-1:0] MODE_ALPHA   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REV_SUB = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAX     = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CLIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_BACK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA  = 3'd6;

    // per-channel blend control shared by all lanes
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] alpha;
    } blend_ctrl_t;

    // inclusive clip rectangle
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] bottom;
    } clip_rect_t;

    // merged result handed to the output register
    typedef struct packed {
        logic                write_enable;
        logic [COLOR_W-1:0]  color;
        logic [STATUS_W-1:0] status;
    } pix_result_t;

endpackage

// ----- design/cpb_lane.sv -----
// ----------------------------------------------------------------------------
// cpb_lane
// One 8-bit color channel blend: alpha add, saturating subtracts, min, max.
// ----------------------------------------------------------------------------
module cpb_lane (
    input  logic [cpb_pkg::CHAN_W-1:0] back_ch,
    input  logic [cpb_pkg::CHAN_W-1:0] fore_ch,
    input  cpb_pkg::blend_ctrl_t       ctrl,
    output logic [cpb_pkg::CHAN_W-1:0] mix_ch
);

    localparam int PROD_W = 2 * cpb_pkg::CHAN_W + 1;

    logic [cpb_pkg::CHAN_W:0]   inv_alpha;
    logic [PROD_W-1:0]          alpha_sum;
    logic                       back_gt;
    logic                       fore_gt;

    // weighted sum, background weight alpha, foreground weight 256 - alpha
    assign inv_alpha = (cpb_pkg::CHAN_W+1)'(1 << cpb_pkg::CHAN_W)
                       - {1'b0, ctrl.alpha};
    assign alpha_sum = PROD_W'(back_ch) * PROD_W'(ctrl.alpha)
                       + PROD_W'(fore_ch) * PROD_W'(inv_alpha);

    assign back_gt = back_ch > fore_ch;
    assign fore_gt = fore_ch > back_ch;

    // mode select, unused codes fall back to alpha add
    always_comb begin
        case (ctrl.mode)
            cpb_pkg::MODE_SUB:     mix_ch = back_gt ? back_ch - fore_ch : '0;
            cpb_pkg::MODE_REV_SUB: mix_ch = fore_gt ? fore_ch - back_ch : '0;
            cpb_pkg::MODE_MIN:     mix_ch = fore_gt ? back_ch : fore_ch;
            cpb_pkg::MODE_MAX:     mix_ch = back_gt ? back_ch : fore_ch;
            default:               mix_ch = alpha_sum[2*cpb_pkg::CHAN_W-1:cpb_pkg::CHAN_W];
        endcase
    end

endmodule

// ----- design/cpb_merge.sv -----
// ----------------------------------------------------------------------------
// cpb_merge
// Combines the lane outputs with the clip test and background check.
// ----------------------------------------------------------------------------
module cpb_merge (
    input  logic signed [cpb_pkg::COORD_W-1:0] pixel_x,
    input  logic signed [cpb_pkg::COORD_W-1:0] pixel_y,
    input  logic [cpb_pkg::COLOR_W-1:0]        fore_color,
    input  logic                               back_valid,
    input  logic [cpb_pkg::COLOR_W-1:0]        lane_color,
    input  cpb_pkg::clip_rect_t                clip,
    input  logic                               blend_enable,
    output cpb_pkg::pix_result_t               result
);

    logic outside;

    // inclusive rectangle test, signed compares
    assign outside = (pixel_x < clip.left) || (pixel_x > clip.right) ||
                     (pixel_y < clip.top)  || (pixel_y > clip.bottom);

    // priority: clip, pass-through, missing background, blend
    always_comb begin
        result.write_enable = 1'b0;
        result.color        = '0;
        result.status       = cpb_pkg::STATUS_WRITTEN;
        if (outside) begin
            result.status = cpb_pkg::STATUS_CLIPPED;
        end else if (!blend_enable) begin
            result.write_enable = 1'b1;
            result.color        = fore_color;
        end else if (!back_valid) begin
            result.status = cpb_pkg::STATUS_NO_BACK;
        end else begin
            result.write_enable = 1'b1;
            result.color        = lane_color;
        end
    end

endmodule

// ----- design/clipped_pixel_blend_unit.sv -----
// ----------------------------------------------------------------------------
// clipped_pixel_blend_unit
// An input transfer's result is registered and presented on the m_ side in the cycle after.
// Throughput: one pixel per cycle while m_tready is high; three channel lanes and
// the clip test run in parallel ahead of a single output register.
// Reset: aresetn low clears the output valid and all clip/blend registers to 0.
// ----------------------------------------------------------------------------
module clipped_pixel_blend_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [cpb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [cpb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // pixel_x[15:0], pixel_y[31:16], fore_color[55:32],
                                   // bg_color[79:56]
    input  logic [0:0]  s_tuser,   // back_valid[0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_x[15:0], out_y[31:16], out_color[55:32]
    output logic [2:0]  m_tuser    // write_enable[0], status[2:1]
);

    localparam int CW = cpb_pkg::CHAN_W;

    // configuration registers
    cpb_pkg::clip_rect_t  clip_reg;
    logic                 blend_enable_reg;
    cpb_pkg::blend_ctrl_t ctrl_reg;

    // input fields
    logic signed [cpb_pkg::COORD_W-1:0] pixel_x;
    logic signed [cpb_pkg::COORD_W-1:0] pixel_y;
    logic [cpb_pkg::COLOR_W-1:0]        fore_color;
    logic [cpb_pkg::COLOR_W-1:0]        bg_color;
    logic [cpb_pkg::COLOR_W-1:0]        lane_color;
    cpb_pkg::pix_result_t               result;

    // output register
    logic                               m_valid_reg;
    logic [cpb_pkg::COORD_W-1:0]        out_x_reg;
    logic [cpb_pkg::COORD_W-1:0]        out_y_reg;
    cpb_pkg::pix_result_t               out_res_reg;
    logic                               s_xfer;

    assign pixel_x    = s_tdata[15:0];
    assign pixel_y    = s_tdata[31:16];
    assign fore_color = s_tdata[55:32];
    assign bg_color   = s_tdata[79:56];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg         <= '0;
            blend_enable_reg <= 1'b0;
            ctrl_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                cpb_pkg::REG_CLIP_LEFT:    clip_reg.left   <= cfg_data;
                cpb_pkg::REG_CLIP_RIGHT:   clip_reg.right  <= cfg_data;
                cpb_pkg::REG_CLIP_TOP:     clip_reg.top    <= cfg_data;
                cpb_pkg::REG_CLIP_BOTTOM:  clip_reg.bottom <= cfg_data;
                cpb_pkg::REG_BLEND_ENABLE: blend_enable_reg <= cfg_data[0];
                cpb_pkg::REG_BLEND_MODE:   ctrl_reg.mode   <= cfg_data[cpb_pkg::MODE_W-1:0];
                cpb_pkg::REG_BLEND_ALPHA:  ctrl_reg.alpha  <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // one blend lane per color channel
    for (genvar ch = 0; ch < cpb_pkg::NUM_CHAN; ch++) begin : g_lane
        cpb_lane u_lane (
            .back_ch (bg_color[ch*CW +: CW]),
            .fore_ch (fore_color[ch*CW +: CW]),
            .ctrl    (ctrl_reg),
            .mix_ch  (lane_color[ch*CW +: CW])
        );
    end

    cpb_merge u_merge (
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .fore_color   (fore_color),
        .back_valid   (s_tuser[0]),
        .lane_color   (lane_color),
        .clip         (clip_reg),
        .blend_enable (blend_enable_reg),
        .result       (result)
    );

    // output register, refilled whenever empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_x_reg   <= pixel_x;
            out_y_reg   <= pixel_y;
            out_res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_res_reg.color, out_y_reg, out_x_reg};
    assign m_tuser  = {out_res_reg.status, out_res_reg.write_enable};

    // a write always reports the written status
    a_we_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == cpb_pkg::STATUS_WRITTEN)
        else $error("write enable with non-written status");

    // a rejected pixel carries a zero color and a reject status
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata[55:32] == '0 &&
            (m_tuser[2:1] == cpb_pkg::STATUS_CLIPPED ||
             m_tuser[2:1] == cpb_pkg::STATUS_NO_BACK))
        else $error("rejected pixel with bad color or status");

    // an accepted pixel is presented on the next cycle
    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted pixel not presented");

    // coordinates follow the accepted item
    a_coord_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tdata[31:0] == $past(s_tdata[31:0]))
        else $error("coordinates not copied");

endmodule

// ----- verif/cpb_blend_checker.sv -----
// ----------------------------------------------------------------------------
// cpb_blend_checker
// Passive scoreboard for the clipped pixel blend unit. It tracks the
// configuration writes, predicts one pixel write per input transfer and
// compares every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module cpb_blend_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cpb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [cpb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [79:0]                     s_tdata,   // pixel_x[15:0], pixel_y[31:16],
                                                       // fore_color[55:32], bg_color[79:56]
    input  logic [0:0]                      s_tuser,   // back_valid[0]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [55:0]                     m_tdata,   // out_x[15:0], out_y[31:16],
                                                       // out_color[55:32]
    input  logic [2:0]                      m_tuser,   // write_enable[0], status[2:1]
    output int                              fail_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                         write_enable;
        logic [cpb_pkg::COORD_W-1:0]  out_x;
        logic [cpb_pkg::COORD_W-1:0]  out_y;
        logic [cpb_pkg::COLOR_W-1:0]  out_color;
        logic [cpb_pkg::STATUS_W-1:0] status;
    } pixel_write_t;

    // shadow copy of the clip and blend registers
    logic signed [cpb_pkg::COORD_W-1:0] clip_left;
    logic signed [cpb_pkg::COORD_W-1:0] clip_right;
    logic signed [cpb_pkg::COORD_W-1:0] clip_top;
    logic signed [cpb_pkg::COORD_W-1:0] clip_bottom;
    logic                               blend_en;
    logic [cpb_pkg::MODE_W-1:0]         blend_mode;
    logic [cpb_pkg::CHAN_W-1:0]         blend_alpha;

    pixel_write_t expected_writes[$];

    // one 8-bit lane of the blend equation
    function automatic logic [cpb_pkg::CHAN_W-1:0] blend_channel(
        logic [cpb_pkg::CHAN_W-1:0] b,
        logic [cpb_pkg::CHAN_W-1:0] f);
        int unsigned weighted;
        case (blend_mode)
            cpb_pkg::MODE_SUB:     return (b > f) ? b - f : '0;
            cpb_pkg::MODE_REV_SUB: return (f > b) ? f - b : '0;
            cpb_pkg::MODE_MIN:     return (b < f) ? b : f;
            cpb_pkg::MODE_MAX:     return (b > f) ? b : f;
            default: begin
                // alpha add, also taken by the unused mode codes
                weighted = b * blend_alpha + f * (256 - blend_alpha);
                return cpb_pkg::CHAN_W'(weighted >> 8);
            end
        endcase
    endfunction

    function automatic pixel_write_t predict_write(
        logic signed [cpb_pkg::COORD_W-1:0] px,
        logic signed [cpb_pkg::COORD_W-1:0] py,
        logic [cpb_pkg::COLOR_W-1:0] fore,
        logic [cpb_pkg::COLOR_W-1:0] back,
        logic back_ok);
        pixel_write_t w;
        w.write_enable = 1'b0;
        w.out_x        = px;
        w.out_y        = py;
        w.out_color    = '0;
        if (px < clip_left || px > clip_right || py < clip_top || py > clip_bottom) begin
            w.status = cpb_pkg::STATUS_CLIPPED;
        end else if (!blend_en) begin
            w.write_enable = 1'b1;
            w.out_color    = fore;
            w.status       = cpb_pkg::STATUS_WRITTEN;
        end else if (!back_ok) begin
            w.status = cpb_pkg::STATUS_NO_BACK;
        end else begin
            for (int ch = 0; ch < cpb_pkg::NUM_CHAN; ch++) begin
                w.out_color[ch*cpb_pkg::CHAN_W +: cpb_pkg::CHAN_W] =
                    blend_channel(back[ch*cpb_pkg::CHAN_W +: cpb_pkg::CHAN_W],
                                  fore[ch*cpb_pkg::CHAN_W +: cpb_pkg::CHAN_W]);
            end
            w.write_enable = 1'b1;
            w.status       = cpb_pkg::STATUS_WRITTEN;
        end
        return w;
    endfunction

    // register shadow, prediction on input transfers, compare on result transfers
    always @(posedge aclk) begin
        pixel_write_t got;
        pixel_write_t want;
        if (!aresetn) begin
            clip_left   = '0;
            clip_right  = '0;
            clip_top    = '0;
            clip_bottom = '0;
            blend_en    = 1'b0;
            blend_mode  = '0;
            blend_alpha = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    cpb_pkg::REG_CLIP_LEFT:
                        clip_left   = cfg_data[cpb_pkg::COORD_W-1:0];
                    cpb_pkg::REG_CLIP_RIGHT:
                        clip_right  = cfg_data[cpb_pkg::COORD_W-1:0];
                    cpb_pkg::REG_CLIP_TOP:
                        clip_top    = cfg_data[cpb_pkg::COORD_W-1:0];
                    cpb_pkg::REG_CLIP_BOTTOM:
                        clip_bottom = cfg_data[cpb_pkg::COORD_W-1:0];
                    cpb_pkg::REG_BLEND_ENABLE:
                        blend_en    = cfg_data[0];
                    cpb_pkg::REG_BLEND_MODE:
                        blend_mode  = cfg_data[cpb_pkg::MODE_W-1:0];
                    cpb_pkg::REG_BLEND_ALPHA:
                        blend_alpha = cfg_data[cpb_pkg::CHAN_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                expected_writes.push_back(predict_write(s_tdata[15:0], s_tdata[31:16],
                                                        s_tdata[55:32], s_tdata[79:56],
                                                        s_tuser[0]));
            end

            if (m_tvalid && m_tready) begin
                got.write_enable = m_tuser[0];
                got.status       = m_tuser[2:1];
                got.out_x        = m_tdata[15:0];
                got.out_y        = m_tdata[31:16];
                got.out_color    = m_tdata[55:32];
                if (expected_writes.size() == 0) begin
                    $error("result transfer with nothing outstanding: x %0d y %0d",
                           $signed(got.out_x), $signed(got.out_y));
                    fail_count++;
                end else begin
                    want = expected_writes.pop_front();
                    if (got.write_enable !== want.write_enable) begin
                        $error("write_enable mismatch: expected %0b, actual %0b",
                               want.write_enable, got.write_enable);
                        fail_count++;
                    end
                    if (got.out_x !== want.out_x) begin
                        $error("out_x mismatch: expected %0d, actual %0d",
                               $signed(want.out_x), $signed(got.out_x));
                        fail_count++;
                    end
                    if (got.out_y !== want.out_y) begin
                        $error("out_y mismatch: expected %0d, actual %0d",
                               $signed(want.out_y), $signed(got.out_y));
                        fail_count++;
                    end
                    if (got.out_color !== want.out_color) begin
                        $error("out_color mismatch: expected %06h, actual %06h",
                               want.out_color, got.out_color);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_writes.size();
    end

endmodule

// ----- verif/clipped_pixel_blend_unit_tb.sv -----
// ----------------------------------------------------------------------------
// clipped_pixel_blend_unit_tb
// Stimulus and verdict for the clipped pixel blend unit. A directed set of
// pixels covers the clip edges, every blend mode and the unreadable background
// case; random pixels under random clip and blend settings follow, with sender
// gaps and receiver back-pressure. The checker does all prediction.
// ----------------------------------------------------------------------------
module clipped_pixel_blend_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // mode codes the block does not define; they fall back to alpha add
    localparam logic [cpb_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [cpb_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int SEGMENTS     = 8;
    localparam int SEG_PIXELS   = 63;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [cpb_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [cpb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [79:0]                    s_tdata   = '0;   // pixel_x, pixel_y, fore_color, bg_color
    logic [0:0]                     s_tuser   = '0;   // back_valid
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [55:0]                    m_tdata;          // out_x, out_y, out_color
    logic [2:0]                     m_tuser;          // write_enable, status

    int fail_count;
    int pending_count;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    always #6 aclk = ~aclk;

    clipped_pixel_blend_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cpb_blend_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // run time guard
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic cfg_write(logic [cpb_pkg::CFG_IDX_W-1:0] idx,
                             logic [cpb_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic program_config(logic [15:0] left, logic [15:0] right,
                                  logic [15:0] top, logic [15:0] bottom,
                                  logic en, logic [cpb_pkg::MODE_W-1:0] mode,
                                  logic [cpb_pkg::CHAN_W-1:0] alpha);
        cfg_write(cpb_pkg::REG_CLIP_LEFT, left);
        cfg_write(cpb_pkg::REG_CLIP_RIGHT, right);
        cfg_write(cpb_pkg::REG_CLIP_TOP, top);
        cfg_write(cpb_pkg::REG_CLIP_BOTTOM, bottom);
        cfg_write(cpb_pkg::REG_BLEND_ENABLE, cpb_pkg::CFG_DATA_W'(en));
        cfg_write(cpb_pkg::REG_BLEND_MODE, cpb_pkg::CFG_DATA_W'(mode));
        cfg_write(cpb_pkg::REG_BLEND_ALPHA, cpb_pkg::CFG_DATA_W'(alpha));
    endtask

    // one pixel transfer, with an optional idle gap in front
    task automatic send_pixel(logic [15:0] px, logic [15:0] py,
                              logic [23:0] fore, logic [23:0] back, logic back_ok);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {back, fore, py, px};
        s_tuser  = back_ok;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending until every outstanding result has come back
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // mostly near the clip windows, sometimes anywhere, sometimes at the edges
    function automatic logic [15:0] random_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return 16'(int'($urandom_range(0, 255)) - 128);
        if (pick < 9) return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            default: return 16'h0000;
        endcase
    endfunction

    initial begin
        int          left_i;
        int          right_i;
        int          top_i;
        int          bottom_i;
        int          shape;
        logic [7:0]  alpha_r;
        logic [23:0] fore_r;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset config: a single-pixel window at the origin, no blending
        send_pixel(16'sd0, 16'sd0, 24'habcdef, 24'h123456, 1'b0);
        send_pixel(16'sd1, 16'sd0, 24'hffffff, 24'h000000, 1'b1);
        send_pixel(-16'sd1, 16'sd0, 24'hffffff, 24'h000000, 1'b1);
        send_pixel(16'sd0, 16'sd1, 24'hffffff, 24'h000000, 1'b1);
        send_pixel(16'sd0, -16'sd1, 24'hffffff, 24'h000000, 1'b1);
        wait_drain();

        // full coordinate range, alpha add with zero background weight
        program_config(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1,
                       cpb_pkg::MODE_ALPHA, 8'd0);
        send_pixel(16'h8000, 16'h8000, 24'hffffff, 24'h000000, 1'b1);
        send_pixel(16'h7fff, 16'h7fff, 24'h000000, 24'hffffff, 1'b1);
        // background read failed while blending
        send_pixel(16'h0010, 16'h0020, 24'h808080, 24'h404040, 1'b0);
        wait_drain();

        cfg_write(cpb_pkg::REG_BLEND_ALPHA, 16'd255);
        send_pixel(16'h7fff, 16'h8000, 24'h00ff7f, 24'hff0080, 1'b1);
        wait_drain();
        cfg_write(cpb_pkg::REG_BLEND_ALPHA, 16'd128);
        send_pixel(16'h1234, 16'hedcb, 24'h10f080, 24'hf01080, 1'b1);
        wait_drain();

        // each compare mode with back above, below and equal to fore per lane
        cfg_write(cpb_pkg::REG_BLEND_MODE, cpb_pkg::CFG_DATA_W'(cpb_pkg::MODE_SUB));
        send_pixel(16'h0001, 16'h0002, 24'h10f080, 24'hf01080, 1'b1);
        wait_drain();
        cfg_write(cpb_pkg::REG_BLEND_MODE, cpb_pkg::CFG_DATA_W'(cpb_pkg::MODE_REV_SUB));
        send_pixel(16'h0003, 16'h0004, 24'h10f080, 24'hf01080, 1'b1);
        wait_drain();
        cfg_write(cpb_pkg::REG_BLEND_MODE, cpb_pkg::CFG_DATA_W'(cpb_pkg::MODE_MIN));
        send_pixel(16'h0005, 16'h0006, 24'h10f080, 24'hf01080, 1'b1);
        wait_drain();
        cfg_write(cpb_pkg::REG_BLEND_MODE, cpb_pkg::CFG_DATA_W'(cpb_pkg::MODE_MAX));
        send_pixel(16'h0007, 16'h0008, 24'h10f080, 24'hf01080, 1'b1);
        wait_drain();

        // undefined mode codes behave as alpha add
        cfg_write(cpb_pkg::REG_BLEND_MODE, cpb_pkg::CFG_DATA_W'(MODE_SPARE_HI));
        send_pixel(16'h0009, 16'h000a, 24'h10f080, 24'hf01080, 1'b1);
        wait_drain();
        cfg_write(cpb_pkg::REG_BLEND_MODE, cpb_pkg::CFG_DATA_W'(MODE_SPARE_LO));
        send_pixel(16'h000b, 16'h000c, 24'hff00ff, 24'h00ff00, 1'b1);
        wait_drain();

        // blending off ignores a failed background read
        cfg_write(cpb_pkg::REG_BLEND_ENABLE, 16'd0);
        send_pixel(16'hfff0, 16'h0100, 24'h5a5a5a, 24'ha5a5a5, 1'b0);
        wait_drain();

        // empty rectangle clips everything
        program_config(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0,
                       cpb_pkg::MODE_ALPHA, 8'd0);
        send_pixel(16'h0000, 16'h0000, 24'hffffff, 24'hffffff, 1'b1);
        wait_drain();

        // random segments, each with its own settings and idle pattern
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                left_i   = -32768;
                right_i  = 32767;
                top_i    = -32768;
                bottom_i = 32767;
            end else if (shape == 1) begin
                left_i   = int'($urandom_range(0, 100));
                right_i  = left_i - 1 - int'($urandom_range(0, 50));
                top_i    = int'($urandom_range(0, 160)) - 112;
                bottom_i = top_i + int'($urandom_range(0, 200));
            end else begin
                left_i   = int'($urandom_range(0, 160)) - 112;
                right_i  = left_i + int'($urandom_range(0, 200));
                top_i    = int'($urandom_range(0, 160)) - 112;
                bottom_i = top_i + int'($urandom_range(0, 200));
            end
            case ($urandom_range(0, 3))
                0:       alpha_r = 8'd0;
                1:       alpha_r = 8'd255;
                default: alpha_r = 8'($urandom);
            endcase
            program_config(16'(left_i), 16'(right_i), 16'(top_i), 16'(bottom_i),
                           $urandom_range(0, 3) != 0,
                           cpb_pkg::MODE_W'($urandom_range(0, 7)),
                           alpha_r);

            case (seg % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 51;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 51;
                end
                default: begin
                    src_idle_pct   = 35;
                    sink_stall_pct = 35;
                end
            endcase

            for (int n = 0; n < SEG_PIXELS; n++) begin
                if ((seg == 1 && n == SEG_PIXELS / 2) || $urandom_range(0, 59) == 0) begin
                    wait_drain();
                end
                fore_r = 24'($urandom);
                send_pixel(random_coord(), random_coord(), fore_r,
                           ($urandom_range(0, 7) == 0) ? fore_r : 24'($urandom),
                           $urandom_range(0, 7) != 0);
            end
            wait_drain();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
